// ===== rtl/assert_macros.svh =====
// Assertion macros for the packet parser RTL.
// Clocked on clk_i, disabled while rst_ni is low; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SRPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SRPP_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SRPP_ASSERT(lbl, prop, msg)
`define SRPP_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/srpp_pkg.sv =====
// Shared constants, controller/datapath interface types and the CRC-8 step.
// No dependencies.
package srpp_pkg;

  localparam int unsigned MaxPayloadDef = 32;

  localparam logic [7:0]  SyncValue   = 8'h55;
  localparam logic [7:0]  TypeRadio   = 8'h01;
  localparam logic [7:0]  CrcPoly     = 8'h07;
  localparam logic [15:0] MinData     = 16'd6;
  localparam logic [15:0] StrengthPos = 16'd5;
  localparam logic [15:0] HdrLast     = 16'd3;

  typedef struct packed {
    logic sync_start;
    logic hdr_byte;
    logic hcrc_pass;
    logic data_byte;
    logic opt_byte;
    logic emit_start;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic hdr_done;
    logic hcrc_ok;
    logic dlen_zero;
    logic olen_zero;
    logic data_done;
    logic opt_done;
    logic frame_good;
    logic emit_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/srpp_ctrl.sv =====
// Frame phase controller: sequences sync, header, data, optional and CRC bytes
// and the result run. Depends on srpp_pkg.
module srpp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  srpp_pkg::sts_t sts_i,
  output srpp_pkg::cmd_t cmd_o
);

  localparam logic [2:0] PhSync   = 3'd0;
  localparam logic [2:0] PhHeader = 3'd1;
  localparam logic [2:0] PhHcrc   = 3'd2;
  localparam logic [2:0] PhData   = 3'd3;
  localparam logic [2:0] PhOpt    = 3'd4;
  localparam logic [2:0] PhDcrc   = 3'd5;
  localparam logic [2:0] PhEmitRd = 3'd6;
  localparam logic [2:0] PhEmitWr = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q == PhEmitRd) || (state_q == PhEmitWr);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      PhSync: begin
        if (accept && sts_i.sync_hit) begin
          cmd_o.sync_start = 1'b1;
          state_d          = PhHeader;
        end
      end
      PhHeader: begin
        if (accept) begin
          cmd_o.hdr_byte = 1'b1;
          if (sts_i.hdr_done) state_d = PhHcrc;
        end
      end
      PhHcrc: begin
        if (accept) begin
          if (!sts_i.hcrc_ok) begin
            state_d = PhSync;
          end else begin
            cmd_o.hcrc_pass = 1'b1;
            if (!sts_i.dlen_zero)      state_d = PhData;
            else if (!sts_i.olen_zero) state_d = PhOpt;
            else                       state_d = PhDcrc;
          end
        end
      end
      PhData: begin
        if (accept) begin
          cmd_o.data_byte = 1'b1;
          if (sts_i.data_done) state_d = sts_i.olen_zero ? PhDcrc : PhOpt;
        end
      end
      PhOpt: begin
        if (accept) begin
          cmd_o.opt_byte = 1'b1;
          if (sts_i.opt_done) state_d = PhDcrc;
        end
      end
      PhDcrc: begin
        if (accept) begin
          if (sts_i.frame_good) begin
            cmd_o.emit_start = 1'b1;
            state_d          = PhEmitRd;
          end else begin
            state_d = PhSync;
          end
        end
      end
      PhEmitRd: begin
        state_d = PhEmitWr;
      end
      PhEmitWr: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = sts_i.emit_last ? PhSync : PhEmitRd;
        end
      end
      default: begin
        state_d = PhSync;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PhSync;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/srpp_dpath.sv =====
// Datapath: byte counter, CRC-8, header fields, payload store, tail window
// and the result register. Depends on srpp_pkg.
module srpp_dpath #(
  parameter int unsigned MaxPayload = srpp_pkg::MaxPayloadDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         rx_byte_i,
  input  srpp_pkg::cmd_t     cmd_i,
  output srpp_pkg::sts_t     sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         radio_org_o,
  output logic [31:0]        sender_addr_o,
  output logic [7:0]         telegram_status_o,
  output logic signed [8:0]  signal_strength_o,
  output logic               strength_present_o,
  output logic [5:0]         payload_length_o,
  output logic [4:0]         payload_index_o,
  output logic [7:0]         payload_byte_o,
  output logic               payload_byte_valid_o,
  output logic               last_o
);

  localparam int unsigned AW  = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned PLW = $clog2(MaxPayload + 1);

  logic [15:0]    bs_q;
  logic [7:0]     crc_q;
  logic [15:0]    dlen_q;
  logic [7:0]     olen_q;
  logic [7:0]     ftype_q;
  logic [39:0]    tw_q;
  logic [7:0]     sb_q;
  logic [7:0]     org_q;
  logic [AW-1:0]  idx_q;
  logic [7:0]     mem_q [MaxPayload];
  logic [7:0]     rd_q;

  logic           out_valid_q;
  logic [7:0]     radio_org_q;
  logic [31:0]    sender_addr_q;
  logic [7:0]     status_q;
  logic [8:0]     strength_q;
  logic           present_q;
  logic [5:0]     plen_out_q;
  logic [4:0]     index_q;
  logic [7:0]     pbyte_q;
  logic           pvalid_q;
  logic           last_q;

  logic [7:0]     crc_next;
  logic [15:0]    bs_inc;
  logic [15:0]    bs_m1;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [15:0]    dlen_m6;
  logic [PLW-1:0] plen;
  logic [PLW-1:0] run_cnt;
  logic           present;

  assign crc_next = srpp_pkg::crc8_update(crc_q, rx_byte_i);
  assign bs_inc   = bs_q + 16'd1;
  assign bs_m1    = bs_q - 16'd1;
  assign wr_en    = (bs_q != 16'd0) && (bs_q <= 16'(MaxPayload));
  assign wr_addr  = bs_m1[AW-1:0];
  assign dlen_m6  = dlen_q - srpp_pkg::MinData;
  assign plen     = (dlen_m6 > 16'(MaxPayload)) ? PLW'(MaxPayload) : dlen_m6[PLW-1:0];
  assign run_cnt  = (plen == '0) ? PLW'(1) : plen;
  assign present  = olen_q > srpp_pkg::StrengthPos[7:0];

  always_comb begin
    sts_o            = '0;
    sts_o.sync_hit   = rx_byte_i == srpp_pkg::SyncValue;
    sts_o.hdr_done   = bs_q == srpp_pkg::HdrLast;
    sts_o.hcrc_ok    = crc_q == rx_byte_i;
    sts_o.dlen_zero  = dlen_q == 16'd0;
    sts_o.olen_zero  = olen_q == 8'd0;
    sts_o.data_done  = ({1'b0, bs_q} + 17'd1) >= {1'b0, dlen_q};
    sts_o.opt_done   = ({1'b0, bs_q} + 17'd1) >= {9'd0, olen_q};
    sts_o.frame_good = (crc_q == rx_byte_i) && (ftype_q == srpp_pkg::TypeRadio)
                       && (dlen_q >= srpp_pkg::MinData);
    sts_o.emit_last  = (PLW'(idx_q) + PLW'(1)) == run_cnt;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q    <= '0;
      crc_q   <= '0;
      dlen_q  <= '0;
      olen_q  <= '0;
      ftype_q <= '0;
      tw_q    <= '0;
      sb_q    <= '0;
      org_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.sync_start) begin
        bs_q  <= '0;
        crc_q <= '0;
        tw_q  <= '0;
        sb_q  <= '0;
      end
      if (cmd_i.hdr_byte) begin
        crc_q <= crc_next;
        bs_q  <= bs_inc;
        case (bs_q[1:0])
          2'd0:    dlen_q       <= {rx_byte_i, 8'h00};
          2'd1:    dlen_q[7:0]  <= rx_byte_i;
          2'd2:    olen_q       <= rx_byte_i;
          default: ftype_q      <= rx_byte_i;
        endcase
      end
      if (cmd_i.hcrc_pass) begin
        bs_q  <= '0;
        crc_q <= '0;
      end
      if (cmd_i.data_byte) begin
        crc_q <= crc_next;
        tw_q  <= {tw_q[31:0], rx_byte_i};
        if (bs_q == 16'd0) org_q <= rx_byte_i;
        bs_q  <= sts_o.data_done ? 16'd0 : bs_inc;
      end
      if (cmd_i.opt_byte) begin
        crc_q <= crc_next;
        if (bs_q == srpp_pkg::StrengthPos) sb_q <= rx_byte_i;
        bs_q  <= sts_o.opt_done ? 16'd0 : bs_inc;
      end
      if (cmd_i.emit_start) idx_q <= '0;
      if (cmd_i.emit_load)  idx_q <= idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.data_byte && wr_en) mem_q[wr_addr] <= rx_byte_i;
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      radio_org_q   <= org_q;
      sender_addr_q <= tw_q[39:8];
      status_q      <= tw_q[7:0];
      strength_q    <= present ? (9'd0 - {1'b0, sb_q}) : 9'd0;
      present_q     <= present;
      plen_out_q    <= 6'(plen);
      index_q       <= 5'(idx_q);
      pbyte_q       <= (plen == '0) ? 8'd0 : rd_q;
      pvalid_q      <= plen != '0;
      last_q        <= sts_o.emit_last;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign radio_org_o          = radio_org_q;
  assign sender_addr_o        = sender_addr_q;
  assign telegram_status_o    = status_q;
  assign signal_strength_o    = $signed(strength_q);
  assign strength_present_o   = present_q;
  assign payload_length_o     = plen_out_q;
  assign payload_index_o      = index_q;
  assign payload_byte_o       = pbyte_q;
  assign payload_byte_valid_o = pvalid_q;
  assign last_o               = last_q;

endmodule

// ===== rtl/serial_radio_packet_parser.sv =====
// Top level of the serial radio packet parser: controller plus datapath.
// Depends on srpp_pkg, srpp_ctrl, srpp_dpath and assert_macros.svh.
//
// Input channel: one received byte per transaction on rx_byte_i (in_valid_i,
// in_stall_o). The parser hunts for sync 0x55, reads a four-byte header and
// its CRC-8, then the data and optional bytes and a closing CRC-8.
// Output channel: one transaction per payload byte of a good radio frame
// (type 1, data length of 6 or more), or a single transaction with
// payload_byte_valid_o low for an empty payload; last_o marks the end.
// Throughput: one byte per cycle while parsing. After the closing CRC byte
// the input stalls for the whole result run; each result is a payload store
// read, then a load of the output register once that register is free.
// The payload store has a single read port, which sets that order.
// Reset clears the phase controller, counters, CRC and output valid; the
// payload store is not cleared, every payload byte sent in a run is first written
// by the same frame. When the receiver stalls, the output register holds
// its result and the run waits.
module serial_radio_packet_parser #(
  parameter int unsigned MaxPayload = srpp_pkg::MaxPayloadDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        radio_org_o,
  output logic [31:0]       sender_addr_o,
  output logic [7:0]        telegram_status_o,
  output logic signed [8:0] signal_strength_o,
  output logic              strength_present_o,
  output logic [5:0]        payload_length_o,
  output logic [4:0]        payload_index_o,
  output logic [7:0]        payload_byte_o,
  output logic              payload_byte_valid_o,
  output logic              last_o
);

  `include "assert_macros.svh"

  srpp_pkg::cmd_t cmd;
  srpp_pkg::sts_t sts;

  srpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srpp_dpath #(
    .MaxPayload (MaxPayload)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .rx_byte_i            (rx_byte_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .radio_org_o          (radio_org_o),
    .sender_addr_o        (sender_addr_o),
    .telegram_status_o    (telegram_status_o),
    .signal_strength_o    (signal_strength_o),
    .strength_present_o   (strength_present_o),
    .payload_length_o     (payload_length_o),
    .payload_index_o      (payload_index_o),
    .payload_byte_o       (payload_byte_o),
    .payload_byte_valid_o (payload_byte_valid_o),
    .last_o               (last_o)
  );

  `SRPP_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(cmd.emit_load), "no load")
  `SRPP_ASSERT(a_load_when_free, cmd.emit_load |-> sts.out_free, "result overwritten")
  `SRPP_ASSERT(a_run_end_resumes, cmd.emit_load && sts.emit_last |=> !in_stall_o, "input held")
  `SRPP_ASSERT(a_cmd_onehot, $onehot0(cmd), "conflicting datapath commands")

endmodule

// ===== bench/serial_radio_packet_parser_check.sv =====
// Transaction monitor for serial_radio_packet_parser: tracks the accepted bytes,
// predicts the telegram results and compares them field by field.
// Depends on srpp_pkg for the framing constants.
`timescale 1ns / 100ps

module serial_radio_packet_parser_check #(
  parameter int unsigned MaxPayload = srpp_pkg::MaxPayloadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] radio_org_i,
  input  logic [31:0] sender_addr_i,
  input  logic [7:0] telegram_status_i,
  input  logic [8:0] signal_strength_i,
  input  logic       strength_present_i,
  input  logic [5:0] payload_length_i,
  input  logic [4:0] payload_index_i,
  input  logic [7:0] payload_byte_i,
  input  logic       payload_byte_valid_i,
  input  logic       last_i,
  output int         errors_o,
  output int         pending_o
);

  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhHead    = 3'd1;
  localparam logic [2:0] PhHeadCrc = 3'd2;
  localparam logic [2:0] PhData    = 3'd3;
  localparam logic [2:0] PhOpt     = 3'd4;
  localparam logic [2:0] PhTailCrc = 3'd5;

  typedef struct packed {
    logic [7:0]  org;
    logic [31:0] sender;
    logic [7:0]  status;
    logic [8:0]  strength;
    logic        present;
    logic [5:0]  plen;
    logic [4:0]  idx;
    logic [7:0]  pbyte;
    logic        pvalid;
    logic        last;
  } telegram_t;

  telegram_t    telegram_q[$];
  logic [2:0]   phase;
  logic [15:0]  frame_dlen;
  logic [7:0]   opt_len;
  logic [7:0]   frame_kind;
  logic [15:0]  byte_count;
  logic [7:0]   frame_crc;
  logic [7:0]   head_bytes [0:MaxPayload];
  logic [39:0]  tail_bytes;
  logic [7:0]   rssi_raw;
  int           fail_count = 0;

  function automatic logic [7:0] crc8_poly07(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? srpp_pkg::CrcPoly : 8'h00);
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_telegram_run();
    int        plen;
    int        runs;
    telegram_t t;
    plen = int'(frame_dlen) - int'(srpp_pkg::MinData);
    if (plen > int'(MaxPayload)) plen = int'(MaxPayload);
    runs = (plen == 0) ? 1 : plen;
    for (int k = 0; k < runs; k++) begin
      t.org      = head_bytes[0];
      t.sender   = tail_bytes[39:8];
      t.status   = tail_bytes[7:0];
      t.present  = (16'(opt_len) > srpp_pkg::StrengthPos);
      t.strength = t.present ? (9'd0 - {1'b0, rssi_raw}) : 9'd0;
      t.plen     = 6'(plen);
      t.idx      = 5'(k);
      t.pbyte    = (plen == 0) ? 8'h00 : head_bytes[k + 1];
      t.pvalid   = (plen != 0);
      t.last     = (k == runs - 1);
      telegram_q = {telegram_q, t};
    end
  endtask

  task automatic track_rx_byte(input logic [7:0] b);
    unique case (phase)
      PhHunt: begin
        if (b == srpp_pkg::SyncValue) begin
          byte_count = '0;
          frame_crc  = '0;
          tail_bytes = '0;
          rssi_raw   = '0;
          phase      = PhHead;
        end
      end
      PhHead: begin
        frame_crc = crc8_poly07(frame_crc, b);
        case (byte_count)
          16'd0:   frame_dlen = {b, 8'h00};
          16'd1:   frame_dlen[7:0] = b;
          16'd2:   opt_len = b;
          default: frame_kind = b;
        endcase
        if (byte_count == srpp_pkg::HdrLast) phase = PhHeadCrc;
        byte_count++;
      end
      PhHeadCrc: begin
        if (frame_crc != b) begin
          phase = PhHunt;
        end else begin
          byte_count = '0;
          frame_crc  = '0;
          if (frame_dlen != 0) phase = PhData;
          else if (opt_len != 0) phase = PhOpt;
          else phase = PhTailCrc;
        end
      end
      PhData: begin
        frame_crc = crc8_poly07(frame_crc, b);
        if (byte_count <= MaxPayload) head_bytes[byte_count] = b;
        tail_bytes = {tail_bytes[31:0], b};
        byte_count++;
        if (byte_count >= frame_dlen) begin
          byte_count = '0;
          phase = (opt_len != 0) ? PhOpt : PhTailCrc;
        end
      end
      PhOpt: begin
        frame_crc = crc8_poly07(frame_crc, b);
        if (byte_count == srpp_pkg::StrengthPos) rssi_raw = b;
        byte_count++;
        if (byte_count >= 16'(opt_len)) begin
          byte_count = '0;
          phase = PhTailCrc;
        end
      end
      PhTailCrc: begin
        if (frame_crc == b && frame_kind == srpp_pkg::TypeRadio
            && frame_dlen >= srpp_pkg::MinData)
          queue_telegram_run();
        phase = PhHunt;
      end
      default: phase = PhHunt;
    endcase
  endtask

  always @(posedge clk_i) begin
    telegram_t want;
    if (!rst_ni) begin
      phase      = PhHunt;
      frame_dlen = '0;
      opt_len    = '0;
      frame_kind = '0;
      byte_count = '0;
      frame_crc  = '0;
      tail_bytes = '0;
      rssi_raw   = '0;
      telegram_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (telegram_q.size() == 0) begin
          $error("telegram result with no expectation waiting");
          fail_count++;
        end else begin
          want = telegram_q.pop_front();
          check_field("radio_org", want.org, radio_org_i);
          check_field("sender_addr", want.sender, sender_addr_i);
          check_field("telegram_status", want.status, telegram_status_i);
          check_field("signal_strength", want.strength, signal_strength_i);
          check_field("strength_present", want.present, strength_present_i);
          check_field("payload_length", want.plen, payload_length_i);
          check_field("payload_index", want.idx, payload_index_i);
          check_field("payload_byte", want.pbyte, payload_byte_i);
          check_field("payload_byte_valid", want.pvalid, payload_byte_valid_i);
          check_field("last", want.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) track_rx_byte(rx_byte_i);
    end
    pending_o <= telegram_q.size();
    errors_o  <= fail_count;
  end

endmodule

// ===== bench/serial_radio_packet_parser_tb.sv =====
// Testbench top for serial_radio_packet_parser: builds framed byte streams
// (good, corrupted, truncated, noise) and gives the verdict.
// Depends on srpp_pkg, the RTL and serial_radio_packet_parser_check.
`timescale 1ns / 100ps

module serial_radio_packet_parser_tb;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  radio_org_o;
  logic [31:0] sender_addr_o;
  logic [7:0]  telegram_status_o;
  logic signed [8:0] signal_strength_o;
  logic        strength_present_o;
  logic [5:0]  payload_length_o;
  logic [4:0]  payload_index_o;
  logic [7:0]  payload_byte_o;
  logic        payload_byte_valid_o;
  logic        last_o;
  int          check_errors;
  int          pending_results;

  logic [7:0]  body_q[$];
  logic        no_gaps = 1'b0;
  int          rx_sent = 0;

  always #2 clk_i = ~clk_i;

  serial_radio_packet_parser DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .rx_byte_i, .out_valid_o, .out_stall_i,
    .radio_org_o, .sender_addr_o, .telegram_status_o, .signal_strength_o,
    .strength_present_o, .payload_length_o, .payload_index_o, .payload_byte_o,
    .payload_byte_valid_o, .last_o
  );

  serial_radio_packet_parser_check telegram_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .rx_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .radio_org_i(radio_org_o), .sender_addr_i(sender_addr_o),
    .telegram_status_i(telegram_status_o), .signal_strength_i(signal_strength_o),
    .strength_present_i(strength_present_o), .payload_length_i(payload_length_o),
    .payload_index_i(payload_index_o), .payload_byte_i(payload_byte_o),
    .payload_byte_valid_i(payload_byte_valid_o), .last_i(last_o),
    .errors_o(check_errors), .pending_o(pending_results)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    rx_sent++;
  endtask

  // hold the input until every predicted telegram has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic send_frame(input logic [15:0] dlen, input logic [7:0] olen,
                            input logic [7:0] ftype, input logic [7:0] hflip,
                            input logic [7:0] dflip, input int cut);
    logic [7:0] hdr [4];
    logic [7:0] crc;
    logic [7:0] frame_bytes[$];
    hdr = '{dlen[15:8], dlen[7:0], olen, ftype};
    frame_bytes = {frame_bytes, srpp_pkg::SyncValue};
    crc = 8'h00;
    foreach (hdr[i]) begin
      frame_bytes = {frame_bytes, hdr[i]};
      crc = srpp_pkg::crc8_update(crc, hdr[i]);
    end
    frame_bytes = {frame_bytes, crc ^ hflip};
    crc = 8'h00;
    foreach (body_q[i]) begin
      frame_bytes = {frame_bytes, body_q[i]};
      crc = srpp_pkg::crc8_update(crc, body_q[i]);
    end
    frame_bytes = {frame_bytes, crc ^ dflip};
    if (cut > 0 && cut < frame_bytes.size())
      repeat (cut) void'(frame_bytes.pop_back());
    foreach (frame_bytes[i]) send_rx_byte(frame_bytes[i]);
  endtask

  initial begin : receiver_stall
    int n;
    @(posedge clk_i);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int          kind;
    int          r;
    int          noise;
    int          cut;
    logic [15:0] dlen;
    logic [7:0]  olen;
    logic [7:0]  ftype;
    logic [7:0]  hflip;
    logic [7:0]  dflip;
    logic        big_done;
    big_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both lengths zero: closing CRC follows the header CRC directly
    body_q.delete();
    send_frame(16'd0, 8'd0, srpp_pkg::TypeRadio, 8'h00, 8'h00, 0);
    // empty payload, strength present at its extreme
    body_q = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_frame(16'd6, 8'd6, srpp_pkg::TypeRadio, 8'h00, 8'h00, 0);
    drain_results();

    while (rx_sent < 320) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) drain_results();
      noise = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 6) : 0;
      repeat (noise) send_rx_byte(8'($urandom));

      ftype = srpp_pkg::TypeRadio;
      hflip = 8'h00;
      dflip = 8'h00;
      cut   = 0;
      r = $urandom_range(0, 9);
      if (r < 5) olen = 8'd0;
      else if (r < 8) olen = 8'($urandom_range(1, 10));
      else olen = 8'($urandom_range(11, 40));
      r = $urandom_range(0, 19);
      if (r < 12) dlen = 16'($urandom_range(6, 14));
      else if (r < 17) dlen = 16'($urandom_range(15, 38));
      else dlen = 16'($urandom_range(39, 48));
      if (!big_done && rx_sent > 20) begin
        dlen = 16'($urandom_range(256, 290));
        big_done = 1'b1;
      end

      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        ftype = 8'($urandom_range(0, 254));
        if (ftype >= srpp_pkg::TypeRadio) ftype = ftype + 8'd1;
      end else if (kind < 20) begin
        dlen = 16'($urandom_range(0, 5));
      end else if (kind < 28) begin
        hflip = 8'($urandom_range(1, 255));
      end else if (kind < 36) begin
        dflip = 8'($urandom_range(1, 255));
      end else if (kind < 42) begin
        cut = $urandom_range(1, 8);
      end

      body_q.delete();
      repeat (int'(dlen) + int'(olen)) body_q = {body_q, 8'($urandom)};
      send_frame(dlen, olen, ftype, hflip, dflip, cut);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (check_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : run_limit
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
